[rtl/core/lsp_pkg.sv]
// lsp_pkg: shared constants and types for the line sensor position block
// no dependencies
`default_nettype none

package lsp_pkg;

    localparam int SENSOR_COUNT = 9;
    localparam int SAMPLE_W     = 8;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int MIDDLE_INDEX = (SENSOR_COUNT - 1) / 2;
    localparam int OFFSET_W     = 7;
    localparam int OFFSET_LIMIT = 60;
    localparam int CONTRAST_W   = 8;
    localparam int SPACING_W    = 4;
    localparam int CFG_DATA_W   = 8;

    // register indexes
    localparam logic CFG_MIN_CONTRAST   = 1'b0;
    localparam logic CFG_SENSOR_SPACING = 1'b1;

    localparam logic [CONTRAST_W-1:0] MIN_CONTRAST_RST   = 8'd30;
    localparam logic [SPACING_W-1:0]  SENSOR_SPACING_RST = 4'd9;

    // floor(x / 11) for x up to 2550 as (x * 745) >> 13
    localparam logic [9:0] RECIP_11    = 10'd745;
    localparam int         RECIP_SHIFT = 13;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]    idx_t;

    typedef struct packed {
        logic found;
        idx_t first;
        idx_t last;
    } run_t;

endpackage

`default_nettype wire

[rtl/core/lsp_run_locate.sv]
// lsp_run_locate: finds the first run of marked sensors
// depends on lsp_pkg
`default_nettype none

module lsp_run_locate
    import lsp_pkg::*;
(
    input  wire logic [SENSOR_COUNT-1:0] mark,
    output run_t                         run
);

    logic [SENSOR_COUNT:0] mark_ext;
    idx_t                  first;
    idx_t                  last;

    assign mark_ext = {1'b0, mark};

    always_comb
    begin
        first = '0;
        for (int i = SENSOR_COUNT - 1; i >= 0; i--)
        begin
            if (mark[i])
            begin
                first = IDX_W'(i);
            end
        end
    end

    // end of run: marked, next one clear, at or after the start
    always_comb
    begin
        last = '0;
        for (int i = SENSOR_COUNT - 1; i >= 0; i--)
        begin
            if (mark[i] && !mark_ext[i + 1] && (IDX_W'(i) >= first))
            begin
                last = IDX_W'(i);
            end
        end
    end

    assign run = {|mark, first, last};

endmodule

`default_nettype wire

[rtl/core/line_sensor_position.sv]
// line_sensor_position: top level, line position from one set of sensor samples
// depends on lsp_pkg and lsp_run_locate
`default_nettype none

// A sample set is taken at every clock edge where start is high; busy stays
// low, so one set per cycle is accepted. The result appears on line_found and
// line_offset with done high for exactly one cycle, after the sample set has
// passed the input register, min/max stage, threshold stage (reciprocal
// multiply for the divide by eleven), then run search and center in the result
// register. The receiver cannot stall; results must be taken as they come.
// Configuration writes are applied at once and should be made while idle.

module line_sensor_position
    import lsp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       cfg_wr,
    input  wire logic                       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [SAMPLE_W-1:0]        sample_0,
    input  wire logic [SAMPLE_W-1:0]        sample_1,
    input  wire logic [SAMPLE_W-1:0]        sample_2,
    input  wire logic [SAMPLE_W-1:0]        sample_3,
    input  wire logic [SAMPLE_W-1:0]        sample_4,
    input  wire logic [SAMPLE_W-1:0]        sample_5,
    input  wire logic [SAMPLE_W-1:0]        sample_6,
    input  wire logic [SAMPLE_W-1:0]        sample_7,
    input  wire logic [SAMPLE_W-1:0]        sample_8,
    output logic                            done,
    output logic                            line_found,
    output logic signed [OFFSET_W-1:0]      line_offset
);

    logic [CONTRAST_W-1:0] min_contrast_reg;
    logic [SPACING_W-1:0]  sensor_spacing_reg;

    sample_t samp1_reg [SENSOR_COUNT];
    sample_t samp2_reg [SENSOR_COUNT];
    sample_t samp3_reg [SENSOR_COUNT];
    logic    v1_reg, v2_reg, v3_reg;
    sample_t min2_reg;
    sample_t diff2_reg;
    logic    ok2_reg;
    sample_t thr3_reg;
    logic    ok3_reg;

    logic                       done_reg;
    logic                       found_reg;
    logic signed [OFFSET_W-1:0] offset_reg;

    sample_t samp_in [SENSOR_COUNT];
    sample_t lo_next, hi_next;
    sample_t thr_next;
    logic [11:0] diff10;
    logic [21:0] quot_prod;

    logic [SENSOR_COUNT-1:0] mark;
    run_t                    run;
    logic [7:0]              center_e;
    logic [7:0]              span;
    logic [7:0]              center;
    logic signed [8:0]       off_full;
    logic signed [OFFSET_W-1:0] offset_next;
    logic                    found_next;

    assign busy = 1'b0;

    assign samp_in[0] = sample_0;
    assign samp_in[1] = sample_1;
    assign samp_in[2] = sample_2;
    assign samp_in[3] = sample_3;
    assign samp_in[4] = sample_4;
    assign samp_in[5] = sample_5;
    assign samp_in[6] = sample_6;
    assign samp_in[7] = sample_7;
    assign samp_in[8] = sample_8;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_contrast_reg   <= MIN_CONTRAST_RST;
            sensor_spacing_reg <= SENSOR_SPACING_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_MIN_CONTRAST:   min_contrast_reg   <= cfg_data[CONTRAST_W-1:0];
                CFG_SENSOR_SPACING: sensor_spacing_reg <= cfg_data[SPACING_W-1:0];
                default:            min_contrast_reg   <= min_contrast_reg;
            endcase
        end
    end

    // min and max over the sample set
    always_comb
    begin
        lo_next = samp1_reg[0];
        hi_next = samp1_reg[0];
        for (int i = 1; i < SENSOR_COUNT; i++)
        begin
            if (samp1_reg[i] > hi_next)
            begin
                hi_next = samp1_reg[i];
            end
            if (samp1_reg[i] < lo_next)
            begin
                lo_next = samp1_reg[i];
            end
        end
    end

    // threshold = min + floor(10 * diff / 11)
    assign diff10    = {1'b0, diff2_reg, 3'b000} + {3'b000, diff2_reg, 1'b0};
    assign quot_prod = diff10 * RECIP_11;
    assign thr_next  = min2_reg + quot_prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];

    always_comb
    begin
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            mark[i] = samp3_reg[i] > thr3_reg;
        end
    end

    lsp_run_locate u_run_locate
    (
        .mark (mark),
        .run  (run)
    );

    // center = spacing*e - floor(spacing*(e-s)/2), offset from middle sensor
    assign center_e = sensor_spacing_reg * run.last;
    assign span     = sensor_spacing_reg * (run.last - run.first);
    assign center   = center_e - {1'b0, span[7:1]};
    assign off_full = $signed({1'b0, center})
                    - $signed(9'(sensor_spacing_reg * MIDDLE_INDEX));

    always_comb
    begin
        if (off_full > 9'sd60)
        begin
            offset_next = 7'(OFFSET_LIMIT);
        end
        else if (off_full < -9'sd60)
        begin
            offset_next = -7'(OFFSET_LIMIT);
        end
        else
        begin
            offset_next = off_full[OFFSET_W-1:0];
        end
    end

    assign found_next = ok3_reg && run.found;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            samp1_reg <= samp_in;
        end
        if (v1_reg)
        begin
            samp2_reg <= samp1_reg;
            min2_reg  <= lo_next;
            diff2_reg <= hi_next - lo_next;
            ok2_reg   <= (hi_next - lo_next) > min_contrast_reg;
        end
        if (v2_reg)
        begin
            samp3_reg <= samp2_reg;
            thr3_reg  <= thr_next;
            ok3_reg   <= ok2_reg;
        end
        if (v3_reg)
        begin
            found_reg  <= found_next;
            offset_reg <= found_next ? offset_next : '0;
        end
    end

    assign done        = done_reg;
    assign line_found  = found_reg;
    assign line_offset = offset_reg;

endmodule

`default_nettype wire

[verif/line_sensor_position_test.sv]
// line_sensor_position_test: self-checking testbench for line_sensor_position
// predicts line_found / line_offset for every sample set and compares each result
// depends on lsp_pkg and the line_sensor_position rtl
`timescale 1ns / 100ps

module line_sensor_position_test;

    import lsp_pkg::*;

    localparam int LATENCY = 4;

    typedef sample_t sample_set_t [SENSOR_COUNT];

    typedef struct packed {
        logic                       found;
        logic signed [OFFSET_W-1:0] offset;
    } line_fix_t;

    class line_position_board;
        int        contrast;
        int        spacing;
        int        errors;
        line_fix_t pending_fixes [$];

        function new();
            contrast = MIN_CONTRAST_RST;
            spacing  = SENSOR_SPACING_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_MIN_CONTRAST)
            begin
                contrast = val;
            end
            else
            begin
                spacing = val[SPACING_W-1:0];
            end
        endfunction

        function int pending();
            return pending_fixes.size();
        endfunction

        function line_fix_t locate_line(sample_set_t v);
            int        lo;
            int        hi;
            int        thr;
            int        first;
            int        last;
            int        ctr;
            int        off;
            int        i;
            line_fix_t fix;
            fix.found  = 1'b0;
            fix.offset = '0;
            lo = v[0];
            hi = v[0];
            for (i = 1; i < SENSOR_COUNT; i++)
            begin
                if (v[i] > hi)
                    hi = v[i];
                if (v[i] < lo)
                    lo = v[i];
            end
            if (lo + contrast >= hi)
                return fix;
            thr   = lo + (10 * (hi - lo)) / 11;
            first = -1;
            last  = -1;
            // only the first run of marked sensors counts
            for (i = 0; i < SENSOR_COUNT; i++)
            begin
                if (v[i] > thr)
                begin
                    if (first < 0)
                    begin
                        first = i;
                        last  = i;
                    end
                    else if (last == i - 1)
                    begin
                        last = i;
                    end
                end
            end
            if (first < 0)
                return fix;
            ctr = spacing * last - (spacing * (last - first)) / 2;
            off = ctr - spacing * MIDDLE_INDEX;
            if (off > OFFSET_LIMIT)
                off = OFFSET_LIMIT;
            if (off < -OFFSET_LIMIT)
                off = -OFFSET_LIMIT;
            fix.found  = 1'b1;
            fix.offset = OFFSET_W'(off);
            return fix;
        endfunction

        function void note_samples(sample_set_t v);
            pending_fixes.push_back(locate_line(v));
        endfunction

        function void check_fix(logic found, logic signed [OFFSET_W-1:0] offset);
            line_fix_t                  want;
            logic signed [OFFSET_W-1:0] want_off;
            if (pending_fixes.size() == 0)
            begin
                $error("unexpected result: line_found %0b line_offset %0d", found, offset);
                errors++;
                return;
            end
            want     = pending_fixes.pop_front();
            want_off = want.offset;
            if (found !== want.found)
            begin
                $error("line_found mismatch: expected %0b, actual %0b", want.found, found);
                errors++;
            end
            if (offset !== want_off)
            begin
                $error("line_offset mismatch: expected %0d, actual %0d", want_off, offset);
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         cfg_wr;
    logic                         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    sample_t                      smp [SENSOR_COUNT];
    logic                         done;
    logic                         line_found;
    logic signed [OFFSET_W-1:0]   line_offset;

    line_position_board board = new();
    int                 xfer_count = 0;

    always #4 clk = ~clk;

    line_sensor_position u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_wr      (cfg_wr),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_0    (smp[0]),
        .sample_1    (smp[1]),
        .sample_2    (smp[2]),
        .sample_3    (smp[3]),
        .sample_4    (smp[4]),
        .sample_5    (smp[5]),
        .sample_6    (smp[6]),
        .sample_7    (smp[7]),
        .sample_8    (smp[8]),
        .done        (done),
        .line_found  (line_found),
        .line_offset (line_offset)
    );

    // input transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            board.note_samples(smp);
            xfer_count++;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_fix(line_found, line_offset);
    end

    function automatic sample_t clip(int x);
        return (x < 0) ? 8'd0 : ((x > 255) ? 8'd255 : x[7:0]);
    endfunction

    function automatic sample_set_t pick_set(int contrast);
        sample_set_t v;
        int          kind;
        int          base;
        int          peak;
        int          noise;
        int          a;
        int          len;
        int          i;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            for (i = 0; i < SENSOR_COUNT; i++)
                v[i] = sample_t'($urandom);
        end
        else if (kind < 6)
        begin
            // spread right around the contrast limit
            base = $urandom_range(0, 255);
            for (i = 0; i < SENSOR_COUNT; i++)
                v[i] = clip(base + $urandom_range(0, contrast));
            v[$urandom_range(0, SENSOR_COUNT - 1)] = clip(base + contrast + $urandom_range(0, 1));
            v[$urandom_range(0, SENSOR_COUNT - 1)] = clip(base);
        end
        else
        begin
            base  = $urandom_range(0, 120);
            peak  = $urandom_range(base, 255);
            noise = $urandom_range(0, 12);
            for (i = 0; i < SENSOR_COUNT; i++)
                v[i] = clip(base + $urandom_range(0, noise));
            a   = $urandom_range(0, SENSOR_COUNT - 1);
            len = $urandom_range(1, SENSOR_COUNT - a);
            for (i = a; i < a + len; i++)
                v[i] = clip(peak - $urandom_range(0, noise));
            if ($urandom_range(0, 3) == 0)
                v[$urandom_range(0, SENSOR_COUNT - 1)] = clip(peak - $urandom_range(0, noise));
        end
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_set(input sample_set_t v);
        int n;
        int i;
        start <= 1'b1;
        for (i = 0; i < SENSOR_COUNT; i++)
            smp[i] <= v[i];
        n = xfer_count;
        do
            @(negedge clk);
        while (xfer_count == n);
    endtask

    task automatic idle(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic set_config(input int contrast, input int spacing);
        write_reg(CFG_MIN_CONTRAST, CFG_DATA_W'(contrast));
        write_reg(CFG_SENSOR_SPACING, CFG_DATA_W'(spacing));
        cfg_wr <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_set('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_set('{255, 255, 255, 255, 255, 255, 255, 255, 255});
        send_set('{255, 0, 0, 0, 0, 0, 0, 0, 0});
        idle(1);
        send_set('{0, 0, 0, 0, 0, 0, 0, 0, 255});
        send_set('{0, 0, 0, 0, 255, 0, 0, 0, 0});
        send_set('{200, 200, 200, 10, 10, 10, 10, 10, 10});
        idle(2);
        send_set('{10, 10, 10, 10, 10, 10, 200, 200, 200});
        send_set('{255, 255, 255, 255, 0, 255, 255, 255, 255});
        send_set('{5, 180, 180, 5, 5, 5, 190, 190, 5});
        // contrast limit at the reset setting
        send_set('{100, 100, 100, 130, 100, 100, 100, 100, 100});
        send_set('{100, 100, 100, 131, 100, 100, 100, 100, 100});
        idle(1);
        // sample equal to the threshold is not marked
        send_set('{0, 31, 33, 30, 31, 0, 0, 0, 0});
        send_set('{0, 255, 0, 255, 0, 255, 0, 255, 0});
        send_set('{0, 250, 250, 250, 250, 250, 250, 250, 250});
        send_set('{0, 32, 64, 96, 128, 160, 192, 224, 255});
        idle(3);
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_set(pick_set(board.contrast));
                sent++;
            end
            if ($urandom_range(0, 15) == 0)
                drain();
            else
                idle($urandom_range(0, 5) * $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_wr    = 1'b0;
        cfg_index = CFG_MIN_CONTRAST;
        cfg_data  = '0;
        for (i = 0; i < SENSOR_COUNT; i++)
            smp[i] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random(150);

        drain();
        set_config(0, 15);
        run_directed();
        run_random(150);

        drain();
        set_config(255, 1);
        run_random(40);

        drain();
        set_config(5, 0);
        run_random(40);

        repeat (4)
        begin
            drain();
            set_config($urandom_range(0, 60), $urandom_range(1, 15));
            run_random(55);
        end

        drain();
        repeat (LATENCY * 2) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
